[hdl/rqrm_pkg.sv]
// Package: shared types, constants and helpers for the ring queue rounded mean block
`default_nettype none

package rqrm_pkg;

    localparam int RING_SLOTS = 8;
    localparam int IDX_W      = $clog2(RING_SLOTS);
    localparam int CNT_W      = $clog2(RING_SLOTS);
    localparam int HEIGHT_W   = 12;
    localparam int TAG_W      = 16;
    localparam int FILL_W     = 3;
    localparam int MEAN_W     = 12;
    localparam int SUM_W      = HEIGHT_W + CNT_W;
    localparam int NUM_W      = SUM_W + 1;
    localparam int DEN_W      = CNT_W + 1;
    localparam int STEP_W     = $clog2(MEAN_W);

    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(RING_SLOTS - 1);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(RING_SLOTS - 1);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic {
        KIND_MEAN   = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    typedef struct packed {
        logic [0:0]          command;
        logic [HEIGHT_W-1:0] height;
        logic [TAG_W-1:0]    record_tag;
    } in_item_t;

    typedef struct packed {
        logic [0:0]          kind;
        logic [MEAN_W-1:0]   mean_height;
        logic [TAG_W-1:0]    removed_tag;
        logic [0:0]          empty_error;
        logic [FILL_W-1:0]   fill_count;
    } out_item_t;

    typedef struct packed {
        logic                rd_en;
        logic [IDX_W-1:0]    rd_addr;
        logic                wr_en;
        logic [IDX_W-1:0]    wr_addr;
        logic [HEIGHT_W-1:0] wr_height;
        logic [TAG_W-1:0]    wr_tag;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_POP,
        ST_WRITE,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        next_idx = (i == IDX_LAST) ? '0 : i + IDX_W'(1);
    endfunction

endpackage

`default_nettype wire

[hdl/rqrm_store.sv]
// Entry store: height and tag memories, one write and one registered read per cycle
`default_nettype none

module rqrm_store
    import rqrm_pkg::*;
(
    input  wire logic                clk,
    input  wire mem_req_t            req,
    output logic [HEIGHT_W-1:0]      rd_height,
    output logic [TAG_W-1:0]         rd_tag
);

    logic [HEIGHT_W-1:0] height_mem [RING_SLOTS];
    logic [TAG_W-1:0]    tag_mem    [RING_SLOTS];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            height_mem[req.wr_addr] <= req.wr_height;
            tag_mem[req.wr_addr]    <= req.wr_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_height <= height_mem[req.rd_addr];
            rd_tag    <= tag_mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/rqrm_divider.sv]
// Restoring divider: one quotient bit per cycle, quotient known to fit in MEAN_W bits
`default_nettype none

module rqrm_divider
    import rqrm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [NUM_W-1:0]   numer,
    input  wire logic [DEN_W-1:0]   denom,
    output logic                    done,
    output logic [MEAN_W-1:0]       quot
);

    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [MEAN_W-1:0] quo_reg, quo_next;

    logic [DEN_W:0]    trial;
    logic              fits;

    // Partial remainder stays below the divisor, so the trial is below twice it
    assign trial = {rem_reg, quo_reg[MEAN_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        quo_next    = quo_reg;
        if (start)
        begin
            active_next = 1'b1;
            step_next   = STEP_W'(MEAN_W - 1);
            rem_next    = numer[NUM_W-1:MEAN_W];
            den_next    = denom;
            quo_next    = numer[MEAN_W-1:0];
        end
        else if (active_reg)
        begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            quo_next = {quo_reg[MEAN_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

[hdl/ring_queue_rounded_mean_core.sv]
// Top level: ring queue with rounded running mean, sequencer around store and divider
// An insert runs write and load, then the 12-step restoring divider, one quotient bit
// per cycle, before its result strobe, with read and pop first when the queue is full
// and the oldest entry is dropped. A remove runs read and pop; an empty remove goes
// straight to the strobe. The next request is taken in the cycle after the strobe.
// Reset (rst_n low, asynchronous) empties the queue and clears the sum; stored entries
// are left as they are. Results cannot be stalled: done is high for exactly one cycle.
`default_nettype none

module ring_queue_rounded_mean_core
    import rqrm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire in_item_t  request,
    output logic           done,
    output out_item_t      result
);

    // Sequencer and queue control state
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;

    // Payload holding registers
    in_item_t          req_reg, req_next;
    out_item_t         res_reg, res_next;

    // Store and divider hook-up
    mem_req_t          mem_req;
    logic [HEIGHT_W-1:0] rd_height;
    logic [TAG_W-1:0]  rd_tag;
    logic              div_start;
    logic              div_done;
    logic [MEAN_W-1:0] div_quot;
    logic [NUM_W-1:0]  div_numer;
    logic [DEN_W-1:0]  div_denom;

    logic accept;
    logic is_full;
    logic is_empty;

    assign accept   = start && (state_reg == ST_IDLE);
    assign is_full  = (cnt_reg == CNT_FULL);
    assign is_empty = (cnt_reg == '0);

    // Rounded half-up mean as (2*sum + count) / (2*count)
    assign div_numer = NUM_W'({sum_reg, 1'b0}) + NUM_W'(cnt_reg);
    assign div_denom = {cnt_reg, 1'b0};

    rqrm_store u_store (
        .clk       (clk),
        .req       (mem_req),
        .rd_height (rd_height),
        .rd_tag    (rd_tag)
    );

    rqrm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (request.command == CMD_INSERT)
                        state_next = is_full ? ST_READ : ST_WRITE;
                    else
                        state_next = is_empty ? ST_DONE : ST_READ;
                end
            end
            ST_READ:  state_next = ST_POP;
            ST_POP:   state_next = (req_reg.command == CMD_INSERT) ? ST_WRITE : ST_DONE;
            ST_WRITE: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_DIV;
            ST_DIV:   state_next = div_done ? ST_DONE : ST_DIV;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control outputs per state
    always_comb
    begin
        mem_req           = '0;
        mem_req.rd_addr   = head_reg;
        mem_req.wr_addr   = tail_reg;
        mem_req.wr_height = req_reg.height;
        mem_req.wr_tag    = req_reg.record_tag;
        div_start         = 1'b0;
        busy              = 1'b1;
        done              = 1'b0;
        unique case (state_reg)
            ST_IDLE:  busy          = 1'b0;
            ST_READ:  mem_req.rd_en = 1'b1;
            ST_WRITE: mem_req.wr_en = 1'b1;
            ST_LOAD:  div_start     = 1'b1;
            ST_DONE:  done          = 1'b1;
            ST_POP, ST_DIV: ;
            default:  busy          = 1'b1;
        endcase
    end

    // Datapath: queue pointers, running sum and result assembly
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        req_next  = req_reg;
        res_next  = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = request;
                    // Empty remove: flag and change nothing
                    res_next             = '0;
                    res_next.kind        = KIND_REMOVE;
                    res_next.empty_error = 1'b1;
                    res_next.fill_count  = FILL_W'(cnt_reg);
                end
            end
            ST_POP:
            begin
                // Drop the oldest entry, either for a remove or to make room
                sum_next  = sum_reg - SUM_W'(rd_height);
                head_next = next_idx(head_reg);
                cnt_next  = cnt_reg - CNT_W'(1);
                res_next             = '0;
                res_next.kind        = KIND_REMOVE;
                res_next.removed_tag = rd_tag;
                res_next.fill_count  = FILL_W'(cnt_reg - CNT_W'(1));
            end
            ST_WRITE:
            begin
                sum_next  = sum_reg + SUM_W'(req_reg.height);
                tail_next = next_idx(tail_reg);
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_next             = '0;
                    res_next.kind        = KIND_MEAN;
                    res_next.mean_height = div_quot;
                    res_next.fill_count  = FILL_W'(cnt_reg);
                end
            end
            ST_READ, ST_LOAD, ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
        end
    end

    // Hold the accepted request and the pending result
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
    end

    assign result = res_reg;

endmodule

`default_nettype wire

[hdl/rqrm_checker.sv]
// Port-level checker for the ring queue rounded mean core, bound to the top level
`default_nettype none

module rqrm_checker
    import rqrm_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      done,
    input wire out_item_t result
);

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a request");

    a_mean_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.kind == KIND_MEAN)) |->
            (result.empty_error == 1'b0 && result.removed_tag == '0
             && result.fill_count != '0))
        else $error("insert result carries remove fields or empty queue");

    a_empty_error: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.empty_error == 1'b1) |->
            (result.kind == KIND_REMOVE && result.fill_count == '0
             && result.removed_tag == '0))
        else $error("empty remove reported with queue state");

endmodule

bind ring_queue_rounded_mean_core rqrm_checker u_rqrm_checker (.*);

`default_nettype wire

[dv/tb_ring_queue_rounded_mean_core.sv]
// Testbench: checks insert and remove requests on the ring queue mean core against a local model
module tb_ring_queue_rounded_mean_core;
    import rqrm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 800;
    localparam int SHOW_LIMIT  = 50;

    // One row of the directed table: the request and, where it can be read
    // off at a glance, the report typed in by hand.
    typedef struct {
        in_item_t  rq;
        bit        has_want;
        out_item_t want;
    } directed_row_t;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      start   = 1'b0;
    in_item_t  request = '0;
    logic      busy;
    logic      done;
    out_item_t result;

    // Local copy of the ring: slots, pointers and the running height sum.
    logic [HEIGHT_W-1:0] ring_height [RING_SLOTS];
    logic [TAG_W-1:0]    ring_tag    [RING_SLOTS];
    int unsigned         ring_head = 0;
    int unsigned         ring_tail = 0;
    int unsigned         ring_sum  = 0;

    // Reports still owed by the block, oldest first.
    out_item_t pending_reports [$];

    int unsigned n_insert    = 0;
    int unsigned n_remove    = 0;
    int unsigned n_empty     = 0;
    int unsigned n_drop      = 0;
    int unsigned n_checked   = 0;
    int unsigned n_fail      = 0;
    int unsigned cycle_count = 0;

    directed_row_t directed_rows [24];

    ring_queue_rounded_mean_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int unsigned held_entries();
        return (ring_tail + RING_SLOTS - ring_head) % RING_SLOTS;
    endfunction

    // Apply one accepted request to the local ring and return the report
    // the block must give for it.
    function automatic out_item_t mean_or_pop_report(input in_item_t rq);
        out_item_t   rep;
        int unsigned cnt;
        rep = '0;
        if (rq.command == CMD_INSERT)
        begin
            n_insert++;
            // Full ring: drop the oldest entry before appending.
            if ((ring_tail + 1) % RING_SLOTS == ring_head)
            begin
                ring_sum  -= ring_height[ring_head];
                ring_head  = (ring_head + 1) % RING_SLOTS;
                n_drop++;
            end
            ring_height[ring_tail] = rq.height;
            ring_tag[ring_tail]    = rq.record_tag;
            ring_sum              += rq.height;
            ring_tail              = (ring_tail + 1) % RING_SLOTS;
            cnt                    = held_entries();
            rep.kind               = KIND_MEAN;
            // Round half up: floor((2*sum + n) / (2*n)).
            rep.mean_height        = MEAN_W'((2 * ring_sum + cnt) / (2 * cnt));
        end
        else
        begin
            n_remove++;
            rep.kind = KIND_REMOVE;
            if (ring_head == ring_tail)
            begin
                // Empty ring: flag it and leave the state alone.
                rep.empty_error = 1'b1;
                n_empty++;
            end
            else
            begin
                rep.removed_tag = ring_tag[ring_head];
                ring_sum       -= ring_height[ring_head];
                ring_head       = (ring_head + 1) % RING_SLOTS;
            end
        end
        rep.fill_count = FILL_W'(held_entries());
        return rep;
    endfunction

    // Hold start low for a random gap, then present the request and hold it
    // until the block takes it. Returns at the accepting edge.
    task automatic send_request(input in_item_t rq, input bit has_want,
                                input out_item_t want, input int idle_pct);
        out_item_t rep;
        int        gap;
        gap = 0;
        while (idle_pct > 0 && gap < 30 && $urandom_range(99) < idle_pct)
            gap++;
        // Now and then stretch the gap so it ends anywhere in a long insert.
        if (idle_pct > 0 && $urandom_range(9) == 0)
            gap = $urandom_range(24, 1);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= rq;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        rep = mean_or_pop_report(rq);
        pending_reports.push_back(has_want ? want : rep);
    endtask

    // Drop start and wait until every owed report has come back.
    task automatic drain_reports();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
    endtask

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            n_fail++;
            if (n_fail <= SHOW_LIMIT)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // Reports cannot be held off: take each one at the edge that ends its
    // strobe cycle and match it against the oldest owed report.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_reports.size() == 0)
            begin
                n_fail++;
                if (n_fail <= SHOW_LIMIT)
                    $display("%0t: unexpected report, expected none, got %p", $time, result);
            end
            else
            begin
                want = pending_reports.pop_front();
                n_checked++;
                compare_field("kind",        want.kind,        result.kind);
                compare_field("mean_height", want.mean_height, result.mean_height);
                compare_field("removed_tag", want.removed_tag, result.removed_tag);
                compare_field("empty_error", want.empty_error, result.empty_error);
                compare_field("fill_count",  want.fill_count,  result.fill_count);
            end
        end
    end

    initial
    begin : stimulus
        in_item_t rq;
        int       idle_pct;
        int       insert_pct;

        directed_rows = '{
            // remove on an empty ring after reset: error, nothing changes
            '{'{CMD_REMOVE, 12'hABC, 16'h1234}, 1'b1, '{KIND_REMOVE, 12'd0, 16'h0000, 1'b1, 3'd0}},
            // top height alone: mean is the height itself
            '{'{CMD_INSERT, 12'hFFF, 16'hFFFF}, 1'b1, '{KIND_MEAN, 12'hFFF, 16'h0000, 1'b0, 3'd1}},
            '{'{CMD_REMOVE, 12'h000, 16'h0000}, 1'b1, '{KIND_REMOVE, 12'd0, 16'hFFFF, 1'b0, 3'd0}},
            '{'{CMD_REMOVE, 12'hFFF, 16'hFFFF}, 1'b1, '{KIND_REMOVE, 12'd0, 16'h0000, 1'b1, 3'd0}},
            '{'{CMD_INSERT, 12'h000, 16'h0000}, 1'b1, '{KIND_MEAN, 12'd0, 16'h0000, 1'b0, 3'd1}},
            // mean of 0 and 1 sits on the half: rounds up
            '{'{CMD_INSERT, 12'h001, 16'h0001}, 1'b0, '0},
            '{'{CMD_REMOVE, 12'h555, 16'hAAAA}, 1'b0, '0},
            '{'{CMD_INSERT, 12'h002, 16'h0002}, 1'b0, '0},
            // fill the ring to its last free slot
            '{'{CMD_INSERT, 12'hFFF, 16'hA5A5}, 1'b0, '0},
            '{'{CMD_INSERT, 12'hFFF, 16'h5A5A}, 1'b0, '0},
            '{'{CMD_INSERT, 12'hFFF, 16'h8001}, 1'b0, '0},
            '{'{CMD_INSERT, 12'hFFF, 16'h7FFE}, 1'b0, '0},
            '{'{CMD_INSERT, 12'hFFF, 16'h00FF}, 1'b0, '0},
            // inserts on a full ring drop the oldest entry first
            '{'{CMD_INSERT, 12'hFFF, 16'hFFFF}, 1'b0, '0},
            '{'{CMD_INSERT, 12'hFFF, 16'h0F0F}, 1'b1, '{KIND_MEAN, 12'hFFF, 16'h0000, 1'b0, 3'd7}},
            '{'{CMD_INSERT, 12'h000, 16'hF0F0}, 1'b0, '0},
            // drain every entry, then one remove too many
            '{'{CMD_REMOVE, 12'h000, 16'h0000}, 1'b0, '0},
            '{'{CMD_REMOVE, 12'hFFF, 16'hFFFF}, 1'b0, '0},
            '{'{CMD_REMOVE, 12'h000, 16'h0000}, 1'b0, '0},
            '{'{CMD_REMOVE, 12'hFFF, 16'hFFFF}, 1'b0, '0},
            '{'{CMD_REMOVE, 12'h000, 16'h0000}, 1'b0, '0},
            '{'{CMD_REMOVE, 12'hFFF, 16'hFFFF}, 1'b0, '0},
            '{'{CMD_REMOVE, 12'h000, 16'h0000}, 1'b0, '0},
            '{'{CMD_REMOVE, 12'hFFF, 16'hFFFF}, 1'b1, '{KIND_REMOVE, 12'd0, 16'h0000, 1'b1, 3'd0}}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].rq, directed_rows[i].has_want,
                         directed_rows[i].want, 0);
        drain_reports();

        // Three phases of sender idling: none, heavy, light. The receiver
        // side has nothing to vary since reports cannot be stalled.
        insert_pct = 50;
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 1) ? 69 : (ph == 2) ? 11 : 0;
            for (int k = 0; k < N_RANDOM / 3; k++)
            begin
                // Re-pick the insert mix per burst so the ring swings between
                // running empty and sitting full with drops.
                if (k % 16 == 0)
                begin
                    case ($urandom_range(2))
                        0:       insert_pct = 25;
                        1:       insert_pct = 50;
                        default: insert_pct = 85;
                    endcase
                end
                if (k == N_RANDOM / 6)
                    drain_reports();
                rq.command    = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
                rq.record_tag = TAG_W'($urandom);
                case ($urandom_range(7))
                    0:       rq.height = '0;
                    1:       rq.height = '1;
                    default: rq.height = HEIGHT_W'($urandom_range(4095));
                endcase
                send_request(rq, 1'b0, '0, idle_pct);
            end
            drain_reports();
        end

        // Leave room for any stray strobe after the last report.
        repeat (24) @(posedge clk);

        $display("covered %0d inserts (%0d with a full-ring drop), %0d removes (%0d on empty)",
                 n_insert, n_drop, n_remove, n_empty);
        $display("%0d reports checked over three idling phases, %0d mismatches",
                 n_checked, n_fail);
        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
hdl/rqrm_pkg.sv
hdl/rqrm_store.sv
hdl/rqrm_divider.sv
hdl/ring_queue_rounded_mean_core.sv
hdl/rqrm_checker.sv
dv/tb_ring_queue_rounded_mean_core.sv
